// ----- rtl/core/psd_pkg.sv -----
// -----------------------------------------------------------------------------
// psd_pkg: shared types and constants
// Region codes, the control word that moves down the pipeline, and the
// fixed widths of the result fields.
// -----------------------------------------------------------------------------
package psd_pkg;

	// Width of the distance result field.
	localparam int DIST_WIDTH = 17;

	// Region in which the projection of the query point falls.
	typedef enum logic [1:0] {
		REG_INTERIOR = 2'd0,
		REG_START    = 2'd1,
		REG_END      = 2'd2,
		REG_DEGEN    = 2'd3
	} region_t;

	// Control word carried alongside the data from the region decision onward.
	typedef struct packed {
		logic    valid;
		region_t region;
	} ctl_t;

endpackage

// ----- rtl/core/psd_if.sv -----
// -----------------------------------------------------------------------------
// psd_in_if / psd_out_if: channel interfaces
// Valid/ready channels for the query and for the result. A transaction
// takes place at a rising edge with valid and ready both high.
// -----------------------------------------------------------------------------
interface psd_in_if #(
	parameter int COORD_WIDTH = 16
) ();
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] point_x;
	logic signed [COORD_WIDTH-1:0] point_y;
	logic signed [COORD_WIDTH-1:0] start_x;
	logic signed [COORD_WIDTH-1:0] start_y;
	logic signed [COORD_WIDTH-1:0] end_x;
	logic signed [COORD_WIDTH-1:0] end_y;

	modport source (
		output valid, point_x, point_y, start_x, start_y, end_x, end_y,
		input  ready
	);
	modport sink (
		input  valid, point_x, point_y, start_x, start_y, end_x, end_y,
		output ready
	);
endinterface

interface psd_out_if ();
	logic                         valid;
	logic                         ready;
	logic [psd_pkg::DIST_WIDTH-1:0] distance;
	logic [1:0]                   region;

	modport source (output valid, distance, region, input ready);
	modport sink (input valid, distance, region, output ready);
endinterface

// ----- rtl/core/point_segment_distance.sv -----
// -----------------------------------------------------------------------------
// point_segment_distance: point to closed segment distance
// Floor of the Euclidean distance from a query point to a segment, with the
// region in which the projection falls.
// -----------------------------------------------------------------------------
// One query is accepted every clock cycle while no finished result waits untaken on
// the output. Each result passes through the front end, the one-bit-per-stage
// divider and the one-bit-per-stage square root. The pipeline moves as a whole:
// while a result waits on the output and is not taken, no stage advances and
// the query channel is not ready. For widths of 16 and above the distance keeps
// its low 17 bits.
module point_segment_distance #(
	parameter int COORD_WIDTH = 16
) (
	input logic        clk,
	input logic        arst_n,
	psd_in_if.sink     query,
	psd_out_if.source  result
);
	import psd_pkg::*;

	localparam int C = 2 * COORD_WIDTH + 3;

	logic                     en;
	ctl_t                     front_ctl, div_ctl, sqrt_in_ctl, sqrt_ctl;
	logic [2*C-1:0]           front_num;
	logic [C-1:0]             front_den, front_sq, div_quot, div_sq, radicand;
	logic [COORD_WIDTH+1:0]   sqrt_root;

	// Whole pipeline advances unless a finished result is held.
	assign en           = !sqrt_ctl.valid || result.ready;
	assign query.ready  = en;

	psd_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (query.valid),
		.point_x  (query.point_x),
		.point_y  (query.point_y),
		.start_x  (query.start_x),
		.start_y  (query.start_y),
		.end_x    (query.end_x),
		.end_y    (query.end_y),
		.ctl      (front_ctl),
		.num      (front_num),
		.den      (front_den),
		.sq       (front_sq)
	);

	psd_div #(.COORD_WIDTH(COORD_WIDTH)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_ctl  (front_ctl),
		.num     (front_num),
		.den     (front_den),
		.in_sq   (front_sq),
		.out_ctl (div_ctl),
		.quot    (div_quot),
		.out_sq  (div_sq)
	);

	// Interior queries take the quotient, the others the endpoint distance.
	assign radicand    = (div_ctl.region == REG_INTERIOR) ? div_quot : div_sq;
	assign sqrt_in_ctl = div_ctl;

	psd_sqrt #(.COORD_WIDTH(COORD_WIDTH)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_ctl   (sqrt_in_ctl),
		.radicand (radicand),
		.out_ctl  (sqrt_ctl),
		.root     (sqrt_root)
	);

	// Result transaction.
	assign result.valid    = sqrt_ctl.valid;
	assign result.distance = DIST_WIDTH'(sqrt_root);
	assign result.region   = sqrt_ctl.region;

`ifndef NO_ASSERTIONS
	// The distance to the line never exceeds the distance to the start point.
	a_quot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(div_ctl.valid && div_ctl.region == REG_INTERIOR) |-> (div_quot <= div_sq))
		else $error("interior quotient exceeds distance to start point");

	// A stall freezes the item leaving the divider.
	a_div_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!en && div_ctl.valid) |=> (div_ctl.valid && $stable(div_quot)))
		else $error("divider output changed during a stall");

	// A stall freezes the front end output.
	a_front_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> ($stable(front_ctl) && $stable(front_den)))
		else $error("front end output changed during a stall");
`endif

endmodule

// ----- rtl/core/psd_front.sv -----
// -----------------------------------------------------------------------------
// psd_front: geometry front end
// Forms the coordinate differences, the squared lengths, the dot and cross
// products, decides the region and squares the cross product over six stages.
// -----------------------------------------------------------------------------
module psd_front #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic signed [COORD_WIDTH-1:0] point_x,
	input  logic signed [COORD_WIDTH-1:0] point_y,
	input  logic signed [COORD_WIDTH-1:0] start_x,
	input  logic signed [COORD_WIDTH-1:0] start_y,
	input  logic signed [COORD_WIDTH-1:0] end_x,
	input  logic signed [COORD_WIDTH-1:0] end_y,
	output psd_pkg::ctl_t                 ctl,
	output logic [4*COORD_WIDTH+5:0]      num,
	output logic [2*COORD_WIDTH+2:0]      den,
	output logic [2*COORD_WIDTH+2:0]      sq
);
	import psd_pkg::*;

	localparam int D  = COORD_WIDTH + 1;
	localparam int P  = 2 * D;
	localparam int C  = 2 * D + 1;
	localparam int NW = 2 * C;
	localparam int K  = C / 2;
	localparam int H  = C - K;

	// Stage 1: differences.
	logic signed [D-1:0] ux_s1, uy_s1, dx_s1, dy_s1, vx_s1, vy_s1;
	logic                v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ux_s1 <= D'(point_x) - D'(start_x);
			uy_s1 <= D'(point_y) - D'(start_y);
			dx_s1 <= D'(end_x) - D'(start_x);
			dy_s1 <= D'(end_y) - D'(start_y);
			vx_s1 <= D'(point_x) - D'(end_x);
			vy_s1 <= D'(point_y) - D'(end_y);
		end
	end

	// Stage 2: the squares and mixed products needed from the differences.
	logic signed [P-1:0] uxux_s2, uyuy_s2, dxdx_s2, dydy_s2, vxvx_s2, vyvy_s2;
	logic signed [P-1:0] uxdx_s2, uydy_s2, dyux_s2, dxuy_s2;
	logic                v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			uxux_s2 <= P'(ux_s1 * ux_s1);
			uyuy_s2 <= P'(uy_s1 * uy_s1);
			dxdx_s2 <= P'(dx_s1 * dx_s1);
			dydy_s2 <= P'(dy_s1 * dy_s1);
			vxvx_s2 <= P'(vx_s1 * vx_s1);
			vyvy_s2 <= P'(vy_s1 * vy_s1);
			uxdx_s2 <= P'(ux_s1 * dx_s1);
			uydy_s2 <= P'(uy_s1 * dy_s1);
			dyux_s2 <= P'(dy_s1 * ux_s1);
			dxuy_s2 <= P'(dx_s1 * uy_s1);
		end
	end

	// Stage 3: sums giving squared lengths, dot and cross products.
	logic [C-1:0]        l2_s3, pa2_s3, pb2_s3;
	logic signed [C-1:0] dot_s3, cr_s3;
	logic                v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			l2_s3  <= C'(dxdx_s2) + C'(dydy_s2);
			pa2_s3 <= C'(uxux_s2) + C'(uyuy_s2);
			pb2_s3 <= C'(vxvx_s2) + C'(vyvy_s2);
			dot_s3 <= C'(uxdx_s2) + C'(uydy_s2);
			cr_s3  <= C'(dyux_s2) - C'(dxuy_s2);
		end
	end

	// Stage 4: region decision, selection of the endpoint distance and cross magnitude.
	region_t      region_d;
	ctl_t         ctl_s4;
	logic [C-1:0] l2_s4, sq_s4, crm_s4;

	always_comb begin
		if (l2_s3 == '0) begin
			region_d = REG_DEGEN;
		end else if (dot_s3[C-1]) begin
			region_d = REG_START;
		end else if (C'(dot_s3) > l2_s3) begin
			region_d = REG_END;
		end else begin
			region_d = REG_INTERIOR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
		end else if (en) begin
			ctl_s4 <= '{valid: v_s3, region: region_d};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			l2_s4  <= l2_s3;
			sq_s4  <= (region_d == REG_END) ? pb2_s3 : pa2_s3;
			crm_s4 <= cr_s3[C-1] ? C'(-cr_s3) : C'(cr_s3);
		end
	end

	// Stage 5: partial products of the squared cross product.
	logic [2*H-1:0] hh_s5;
	logic [C-1:0]   hl_s5;
	logic [2*K-1:0] ll_s5;
	ctl_t           ctl_s5;
	logic [C-1:0]   l2_s5, sq_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s5 <= '0;
		end else if (en) begin
			ctl_s5 <= ctl_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hh_s5 <= (2*H)'(crm_s4[C-1:K]) * (2*H)'(crm_s4[C-1:K]);
			hl_s5 <= C'(crm_s4[C-1:K]) * C'(crm_s4[K-1:0]);
			ll_s5 <= (2*K)'(crm_s4[K-1:0]) * (2*K)'(crm_s4[K-1:0]);
			l2_s5 <= l2_s4;
			sq_s5 <= sq_s4;
		end
	end

	// Stage 6: assemble the full squared cross product.
	ctl_t          ctl_s6;
	logic [NW-1:0] num_s6;
	logic [C-1:0]  l2_s6, sq_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s6 <= '0;
		end else if (en) begin
			ctl_s6 <= ctl_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s6 <= (NW'(hh_s5) << (2*K)) + (NW'(hl_s5) << (K+1)) + NW'(ll_s5);
			l2_s6  <= l2_s5;
			sq_s6  <= sq_s5;
		end
	end

	assign ctl = ctl_s6;
	assign num = num_s6;
	assign den = l2_s6;
	assign sq  = sq_s6;

endmodule

// ----- rtl/core/psd_div.sv -----
// -----------------------------------------------------------------------------
// psd_div: pipelined restoring divider
// Divides the squared cross product by the squared segment length, one
// quotient bit per stage. The quotient is known to fit in the denominator width.
// -----------------------------------------------------------------------------
module psd_div #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  psd_pkg::ctl_t            in_ctl,
	input  logic [4*COORD_WIDTH+5:0] num,
	input  logic [2*COORD_WIDTH+2:0] den,
	input  logic [2*COORD_WIDTH+2:0] in_sq,
	output psd_pkg::ctl_t            out_ctl,
	output logic [2*COORD_WIDTH+2:0] quot,
	output logic [2*COORD_WIDTH+2:0] out_sq
);
	import psd_pkg::*;

	localparam int C  = 2 * COORD_WIDTH + 3;
	localparam int NW = 2 * C;
	localparam int Q  = C;

	// Entry 0 is the stage input; entry i+1 is the register after step i.
	ctl_t         ctl_s [Q+1];
	logic [C-1:0] rem_s [Q+1];
	logic [Q-1:0] low_s [Q+1];
	logic [C-1:0] den_s [Q+1];
	logic [C-1:0] sq_s  [Q+1];

	assign ctl_s[0] = in_ctl;
	assign rem_s[0] = num[NW-1:Q];
	assign low_s[0] = num[Q-1:0];
	assign den_s[0] = den;
	assign sq_s[0]  = in_sq;

	for (genvar i = 0; i < Q; i++) begin : g_step
		logic [C:0]   trial;
		logic         ge;
		logic [C-1:0] rem_next;

		// One shift-compare-subtract step.
		always_comb begin
			trial    = {rem_s[i], low_s[i][Q-1]};
			ge       = trial >= {1'b0, den_s[i]};
			rem_next = ge ? C'(trial - {1'b0, den_s[i]}) : C'(trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[i+1] <= '0;
			end else if (en) begin
				ctl_s[i+1] <= ctl_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= rem_next;
				low_s[i+1] <= {low_s[i][Q-2:0], ge};
				den_s[i+1] <= den_s[i];
				sq_s[i+1]  <= sq_s[i];
			end
		end
	end

	assign out_ctl = ctl_s[Q];
	assign quot    = low_s[Q];
	assign out_sq  = sq_s[Q];

endmodule

// ----- rtl/core/psd_sqrt.sv -----
// -----------------------------------------------------------------------------
// psd_sqrt: pipelined integer square root
// Digit-by-digit square root, one result bit per stage, rounding down.
// -----------------------------------------------------------------------------
module psd_sqrt #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  psd_pkg::ctl_t          in_ctl,
	input  logic [2*COORD_WIDTH+2:0] radicand,
	output psd_pkg::ctl_t          out_ctl,
	output logic [COORD_WIDTH+1:0] root
);
	import psd_pkg::*;

	localparam int RB   = COORD_WIDTH + 2;
	localparam int XW   = 2 * RB;
	localparam int REMW = RB + 2;

	ctl_t            ctl_s  [RB+1];
	logic [REMW-1:0] rem_s  [RB+1];
	logic [RB-1:0]   root_s [RB+1];
	logic [XW-1:0]   x_s    [RB+1];

	assign ctl_s[0]  = in_ctl;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign x_s[0]    = XW'(radicand);

	for (genvar k = 0; k < RB; k++) begin : g_step
		logic [REMW+1:0] acc;
		logic [REMW+1:0] trial;
		logic            ge;

		// Bring down two bits and try the next root bit.
		always_comb begin
			acc   = {rem_s[k], x_s[k][XW-1:XW-2]};
			trial = (REMW+2)'({root_s[k], 2'b01});
			ge    = acc >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k+1] <= '0;
			end else if (en) begin
				ctl_s[k+1] <= ctl_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? REMW'(acc - trial) : REMW'(acc);
				root_s[k+1] <= {root_s[k][RB-2:0], ge};
				x_s[k+1]    <= {x_s[k][XW-3:0], 2'b00};
			end
		end
	end

	assign out_ctl = ctl_s[RB];
	assign root    = root_s[RB];

endmodule

// ----- tb/sv/point_segment_distance_test.sv -----
// -----------------------------------------------------------------------------
// point_segment_distance_test: self-checking testbench
// Feeds directed and random queries through the query channel, predicts each
// distance and region with exact wide integer arithmetic, and checks every
// result transaction in order while both channels idle at random in the first two thirds of the run.
// -----------------------------------------------------------------------------
module point_segment_distance_test;
	import psd_pkg::*;

	localparam int CW = 16;

	typedef struct {
		logic signed [CW-1:0] px, py, ax, ay, bx, by;
	} query_t;

	typedef struct {
		logic [DIST_WIDTH-1:0] distance;
		region_t               region;
	} answer_t;

	logic clk;
	logic arst_n;

	psd_in_if #(.COORD_WIDTH(CW)) query_ch ();
	psd_out_if result_ch ();

	point_segment_distance #(.COORD_WIDTH(CW)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.query  (query_ch),
		.result (result_ch)
	);

	query_t  pending[$];
	answer_t awaited[$];
	int      total_queries;
	int      accepted;
	int      errors;
	logic    query_fired;
	logic    loading_done;

	// Clock with a period of 8 time units.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Floor of the square root, bit by bit from the top.
	function automatic logic [63:0] floor_sqrt(input logic [127:0] n);
		logic [63:0]  root;
		logic [63:0]  cand;
		logic [127:0] sq;
		root = '0;
		for (int b = 46; b >= 0; b--) begin
			cand = root | (64'd1 << b);
			sq = {64'd0, cand} * {64'd0, cand};
			if (sq <= n)
				root = cand;
		end
		return root;
	endfunction

	// Distance from the point to the closed segment, and the region.
	function automatic answer_t segment_distance(input query_t q);
		logic signed [127:0] px, py, ax, ay, bx, by;
		logic signed [127:0] ux, uy, dx, dy, len2, dot, crs;
		answer_t a;
		px = q.px; py = q.py; ax = q.ax; ay = q.ay; bx = q.bx; by = q.by;
		ux = px - ax; uy = py - ay;
		dx = bx - ax; dy = by - ay;
		len2 = dx * dx + dy * dy;
		if (len2 == 0) begin
			a.region = REG_DEGEN;
			a.distance = DIST_WIDTH'(floor_sqrt(ux * ux + uy * uy));
		end else begin
			dot = ux * dx + uy * dy;
			if (dot < 0) begin
				a.region = REG_START;
				a.distance = DIST_WIDTH'(floor_sqrt(ux * ux + uy * uy));
			end else if (dot > len2) begin
				a.region = REG_END;
				a.distance = DIST_WIDTH'(floor_sqrt((px - bx) * (px - bx)
					+ (py - by) * (py - by)));
			end else begin
				crs = dy * ux - dx * uy;
				a.region = REG_INTERIOR;
				a.distance = DIST_WIDTH'(floor_sqrt((crs * crs) / len2));
			end
		end
		return a;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch in %s: got %0d, expected %0d", what, got, want);
		errors++;
	endtask

	// Idle percentages for the three phases of the run.
	function automatic int sender_idle();
		if (accepted < total_queries / 3)
			return 7;
		if (accepted < 2 * total_queries / 3)
			return 47;
		return 0;
	endfunction

	function automatic int receiver_idle();
		if (accepted < total_queries / 3)
			return 47;
		if (accepted < 2 * total_queries / 3)
			return 7;
		return 0;
	endfunction

	// Query driver: a new transaction is presented only once the last is taken.
	always @(negedge clk) begin
		if (!arst_n) begin
			query_ch.valid <= 1'b0;
		end else if (!query_ch.valid || query_fired) begin
			if (pending.size() > 0 && $urandom_range(99) >= sender_idle()) begin
				query_t q;
				q = pending.pop_front();
				query_ch.point_x <= q.px;
				query_ch.point_y <= q.py;
				query_ch.start_x <= q.ax;
				query_ch.start_y <= q.ay;
				query_ch.end_x   <= q.bx;
				query_ch.end_y   <= q.by;
				query_ch.valid   <= 1'b1;
			end else begin
				query_ch.valid <= 1'b0;
			end
		end
	end

	// Result back-pressure.
	always @(negedge clk) begin
		if (!arst_n)
			result_ch.ready <= 1'b0;
		else
			result_ch.ready <= ($urandom_range(99) >= receiver_idle());
	end

	// Query monitor: predict the answer for every accepted transaction.
	always @(posedge clk) begin
		query_t q;
		query_fired <= query_ch.valid && query_ch.ready;
		if (arst_n && query_ch.valid && query_ch.ready) begin
			q.px = query_ch.point_x; q.py = query_ch.point_y;
			q.ax = query_ch.start_x; q.ay = query_ch.start_y;
			q.bx = query_ch.end_x;   q.by = query_ch.end_y;
			awaited.push_back(segment_distance(q));
			accepted++;
		end
	end

	// Result monitor: compare with the oldest awaited answer.
	always @(posedge clk) begin
		answer_t a;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (awaited.size() == 0) begin
				$display("result transaction with nothing awaited");
				errors++;
			end else begin
				a = awaited.pop_front();
				if (result_ch.distance !== a.distance)
					report_mismatch("distance", result_ch.distance, a.distance);
				if (result_ch.region !== a.region)
					report_mismatch("region", result_ch.region, a.region);
			end
		end
	end

	function automatic logic signed [CW-1:0] any_coord();
		return CW'($urandom);
	endfunction

	task automatic add_query(input int px, py, ax, ay, bx, by);
		query_t q;
		q.px = CW'(px); q.py = CW'(py); q.ax = CW'(ax);
		q.ay = CW'(ay); q.bx = CW'(bx); q.by = CW'(by);
		pending.push_back(q);
		total_queries++;
	endtask

	// Random query: full-range or small-span coordinates, sometimes a degenerate segment or a point on its line.
	task automatic add_random_query();
		int px, py, ax, ay, bx, by, kind, span;
		kind = $urandom_range(9);
		span = ($urandom_range(1) == 1) ? 32767 : $urandom_range(64);
		ax = $urandom_range(2 * span) - span;
		ay = $urandom_range(2 * span) - span;
		bx = $urandom_range(2 * span) - span;
		by = $urandom_range(2 * span) - span;
		px = $urandom_range(2 * span) - span;
		py = $urandom_range(2 * span) - span;
		case (kind)
			0: begin
				bx = ax; by = ay;
			end
			1: begin
				// Point on the line through the segment.
				px = ax + (bx - ax) * ($urandom_range(4) - 1);
				py = ay + (by - ay) * ($urandom_range(4) - 1);
			end
			2: begin
				px = any_coord(); py = any_coord(); ax = any_coord();
				ay = any_coord(); bx = any_coord(); by = any_coord();
			end
			default: ;
		endcase
		add_query(px, py, ax, ay, bx, by);
	endtask

	// Stimulus and end of run.
	initial begin
		errors = 0;
		accepted = 0;
		total_queries = 0;
		query_fired = 1'b0;
		arst_n = 1'b0;
		query_ch.valid = 1'b0;
		query_ch.point_x = '0; query_ch.point_y = '0;
		query_ch.start_x = '0; query_ch.start_y = '0;
		query_ch.end_x = '0;   query_ch.end_y = '0;
		result_ch.ready = 1'b0;

		// Extremes, every region, and projections exactly on an endpoint.
		add_query(-32768, -32768, 32767, 32767, 32767, 32767);
		add_query(32767, 32767, -32768, -32768, -32768, -32768);
		add_query(0, 0, 0, 0, 0, 0);
		add_query(-32768, 32767, 32767, -32768, -32768, -32768);
		add_query(32767, -32768, -32768, 32767, 32767, 32767);
		add_query(0, 5, -10, 0, 10, 0);
		add_query(-20, 3, -10, 0, 10, 0);
		add_query(25, -4, -10, 0, 10, 0);
		add_query(-10, 7, -10, 0, 10, 0);
		add_query(10, -7, -10, 0, 10, 0);
		add_query(3, 3, 0, 0, 6, 6);
		add_query(-32768, 0, -32768, -32768, -32768, 32767);
		add_query(32767, 0, -32768, -32768, -32768, 32767);
		add_query(0, 32767, -32768, -32768, 32767, -32768);
		add_query(0, 0, -32768, -32768, 32767, 32767);
		add_query(32767, -32768, -32768, -32768, 32767, 32767);
		add_query(-1, -1, 1, 1, 1, 1);
		add_query(1, 0, 0, 0, 1, 1);
		add_query(-32768, -32768, 0, 0, 1, 0);
		add_query(32767, 32767, 0, 0, -1, 0);
		add_query(12345, -23456, -32768, 32767, 32767, -32768);
		repeat (1100) add_random_query();

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (accepted < total_queries || awaited.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Watchdog.
	initial begin
		#4000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/psd_pkg.sv
rtl/core/psd_if.sv
rtl/core/psd_front.sv
rtl/core/psd_div.sv
rtl/core/psd_sqrt.sv
rtl/core/point_segment_distance.sv
tb/sv/point_segment_distance_test.sv
